// ===== src/tplru_pkg.sv =====
package tplru_pkg;

  localparam int LEAF_COUNT_DEF = 8192;
  localparam int LEAF_W         = 13;
  localparam int DATA_W         = 16;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } tplru_state_t;

  typedef struct packed {
    logic clear;
    logic touch;
    logic start;
    logic step;
    logic out_load;
  } tplru_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_last;
    logic out_free;
  } tplru_sts_t;

endpackage

// ===== src/tplru_ram.sv =====
module tplru_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tplru_ctrl.sv =====
module tplru_ctrl import tplru_pkg::*; #(
  parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  tplru_sts_t sts,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  output tplru_cmd_t cmd
);

  localparam int LEVELS = $clog2(LEAF_COUNT);

  tplru_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op) begin
            cmd.start  = 1'b1;
            state_next = (LEVELS > 1) ? ST_WALK : ST_FINISH;
          end else begin
            cmd.touch = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== src/tplru_datapath.sv =====
module tplru_datapath import tplru_pkg::*; #(
  parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tplru_cmd_t        cmd,
  output tplru_sts_t        sts,
  input  logic [LEAF_W-1:0] leaf_index,
  output logic [LEAF_W-1:0] victim_leaf,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam int LEVELS   = $clog2(LEAF_COUNT);
  localparam int CLR_LAST = LEAF_COUNT / 2 - 1;

  logic                     root;
  logic [LEVELS-1:0]        path, path_next;
  logic [LEVELS-1:0]        lvl_oh;
  logic [LEVELS-1:0]        clr_cnt;
  logic [LEVELS-1:0]        rd_bits;
  logic [LEVELS+LEAF_W-1:0] leaf_ext;
  logic [LEVELS-1:0]        leafk;
  logic [LEVELS+LEAF_W-1:0] victim_ext;
  logic [LEVELS:0]          path_sh;
  logic [LEVELS:0]          lvl_sh;
  logic                     dir;

  assign leaf_ext   = {{LEVELS{1'b0}}, leaf_index};
  assign leafk      = leaf_ext[LEVELS-1:0];
  assign victim_ext = {{LEAF_W{1'b0}}, path};

  assign rd_bits[0] = root;
  assign dir        = |(rd_bits & lvl_oh);
  assign path_sh    = {path, dir};
  assign lvl_sh     = {lvl_oh, 1'b0};

  always_comb begin
    path_next = path;
    if (cmd.start) begin
      path_next = LEVELS'(root);
    end else if (cmd.step) begin
      path_next = path_sh[LEVELS-1:0];
    end
  end

  // one memory per tree level below the root; level g holds 2**g node bits
  for (genvar g = 1; g < LEVELS; g++) begin : g_level
    logic         we;
    logic [g-1:0] waddr;
    logic         wdata;

    always_comb begin
      we = cmd.clear | cmd.touch | (cmd.step & lvl_oh[g]);
      priority if (cmd.clear) begin
        waddr = clr_cnt[g-1:0];
        wdata = 1'b0;
      end else if (cmd.touch) begin
        waddr = leafk[LEVELS-1 -: g];
        wdata = ~leafk[LEVELS-1-g];
      end else begin
        waddr = path[g-1:0];
        wdata = ~dir;
      end
    end

    tplru_ram #(
      .WIDTH (1),
      .DEPTH (2 ** g)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (path_next[g-1:0]),
      .rdata (rd_bits[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root    <= 1'b1;
      clr_cnt <= '0;
      lvl_oh  <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.touch) begin
        root <= ~leafk[LEVELS-1];
      end else if (cmd.start) begin
        root <= ~root;
      end
      if (cmd.start) begin
        lvl_oh <= LEVELS'(2);
      end else if (cmd.step) begin
        lvl_oh <= lvl_sh[LEVELS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    path <= path_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      victim_leaf <= victim_ext[LEAF_W-1:0];
    end
  end

  assign sts.clear_done = (clr_cnt == LEVELS'(CLR_LAST));
  assign sts.walk_last  = lvl_oh[LEVELS-1];
  assign sts.out_free   = ~out_valid | out_ready;

endmodule

// ===== src/tree_plru_replacement.sv =====
// Tree pseudo-LRU replacement over LEAF_COUNT leaves (power of two).
// Input stream s_*: tuser is the op (0 touch, 1 victim request), tdata
// carries the leaf to touch. Output stream m_*: one victim leaf per
// victim request, none for a touch.
// A touch is done in the cycle it is accepted; the next request can be
// taken in the following cycle.
// A victim request walks the tree one level per cycle, the level memory
// read port setting the pace: the root is handled at acceptance, each
// further level in the walk state, and the finish state then loads the
// output register. No new request is taken until that load is done.
// Reset: rst clears the tree; a clearing pass of LEAF_COUNT/2 addresses
// then zeroes the level memories, with s_tready low. Afterwards the root
// points right and all other nodes left.
// A stalled receiver holds the result in the output register; touches are
// still taken, and a victim request waits at its end until the register
// frees.
module tree_plru_replacement import tplru_pkg::*; #(
  parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [12:0] leaf_index
  input  logic              s_tuser,   // [0] op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata    // [12:0] victim_leaf
);

  tplru_cmd_t        cmd;
  tplru_sts_t        sts;
  logic [LEAF_W-1:0] victim_leaf;

  tplru_ctrl #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  tplru_datapath #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .leaf_index  (s_tdata[LEAF_W-1:0]),
    .victim_leaf (victim_leaf),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready)
  );

  assign m_tdata = {{(DATA_W-LEAF_W){1'b0}}, victim_leaf};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

import tplru_pkg::*;

typedef enum bit {
  OP_TOUCH  = 1'b0,
  OP_VICTIM = 1'b1
} plru_op_e;

class victim_scoreboard;
  localparam int TREE_NODES = LEAF_COUNT_DEF - 1;

  bit                node_q [0:TREE_NODES-1];
  logic [LEAF_W-1:0] victim_q [$];
  int                errors;

  function new();
    foreach (node_q[i]) node_q[i] = 1'b0;
    node_q[0] = 1'b1;
    errors = 0;
  endfunction

  function int pending();
    return victim_q.size();
  endfunction

  task report(string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  // touch points every node on the path away from the leaf; a victim request
  // walks down, flipping each node it passes
  function void note_request(plru_op_e op, logic [LEAF_W-1:0] leaf);
    int pos;
    int parent;
    bit dir;
    if (op == OP_TOUCH) begin
      pos = int'(leaf) + TREE_NODES;
      while (pos != 0) begin
        parent = (pos - 1) / 2;
        node_q[parent] = pos[0];
        pos = parent;
      end
    end else begin
      pos = 0;
      while (pos < TREE_NODES) begin
        dir = node_q[pos];
        node_q[pos] = ~dir;
        pos = dir ? 2 * pos + 2 : 2 * pos + 1;
      end
      victim_q.push_back(LEAF_W'(pos - TREE_NODES));
    end
  endfunction

  task check_result(logic [DATA_W-1:0] data);
    logic [LEAF_W-1:0] exp_leaf;
    if (victim_q.size() == 0) begin
      report($sformatf("victim_leaf %0d with no request outstanding", data[LEAF_W-1:0]));
    end else begin
      exp_leaf = victim_q.pop_front();
      if (data[LEAF_W-1:0] !== exp_leaf)
        report($sformatf("victim_leaf %0d, expected %0d", data[LEAF_W-1:0], exp_leaf));
    end
  endtask
endclass

module tb;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;

  int send_idle = 36;
  int recv_idle = 83;

  victim_scoreboard sb = new();

  tree_plru_replacement #(
    .LEAF_COUNT(LEAF_COUNT_DEF)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_request(plru_op_e'(s_tuser), s_tdata[LEAF_W-1:0]);
    end
  end

  task send_request(plru_op_e op, logic [LEAF_W-1:0] leaf);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(DATA_W-LEAF_W){1'b0}}, leaf};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold off until every outstanding victim has come back
  task drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function logic [LEAF_W-1:0] pick_leaf();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return LEAF_W'($urandom_range(LEAF_COUNT_DEF - 1));
    endcase
  endfunction

  task random_phase(int n_items);
    int sent;
    int burst;
    logic [LEAF_W-1:0] leaf;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          send_request(OP_TOUCH, pick_leaf());
          sent++;
        end
        9, 10, 11, 12, 13, 14: begin
          send_request(OP_VICTIM, LEAF_W'($urandom));
          sent++;
        end
        15, 16, 17: begin
          burst = $urandom_range(5, 2);
          repeat (burst) send_request(OP_VICTIM, LEAF_W'($urandom));
          sent += burst;
        end
        default: begin
          // neighbors or repeats of one leaf, then a victim
          leaf = pick_leaf();
          burst = $urandom_range(4, 2);
          repeat (burst) begin
            send_request(OP_TOUCH, leaf);
            if ($urandom_range(1)) leaf = leaf + 1'b1;
          end
          send_request(OP_VICTIM, leaf);
          sent += burst + 1;
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_VICTIM, '0);
    send_request(OP_VICTIM, '1);
    send_request(OP_VICTIM, '0);
    send_request(OP_TOUCH, '0);
    send_request(OP_VICTIM, '0);
    send_request(OP_TOUCH, '1);
    send_request(OP_VICTIM, '1);
    send_request(OP_TOUCH, 13'h1000);
    send_request(OP_TOUCH, 13'h0fff);
    send_request(OP_VICTIM, 13'h1555);
    send_request(OP_TOUCH, 13'h1555);
    send_request(OP_TOUCH, 13'h0aaa);
    send_request(OP_VICTIM, 13'h0aaa);
    send_request(OP_VICTIM, '0);
    send_request(OP_TOUCH, '1);
    send_request(OP_TOUCH, '1);
    send_request(OP_VICTIM, '0);
    send_request(OP_TOUCH, 13'h0001);
    send_request(OP_TOUCH, 13'h1ffe);
    send_request(OP_VICTIM, '1);
    send_request(OP_VICTIM, '0);
    drain();

    random_phase(245);
    drain();
    send_idle = 83;
    recv_idle = 36;
    random_phase(245);
    drain();
    send_idle = 0;
    recv_idle = 0;
    random_phase(245);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS tree_plru_replacement");
    else
      $display("FAIL tree_plru_replacement");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d victims outstanding", sb.pending());
    $display("FAIL tree_plru_replacement");
    $finish;
  end

endmodule
